FILE: hdl/tbr_pkg.sv
// shared types for the triangle bounding-box rasterizer
package tbr_pkg;

    // per-pixel marks carried alongside the coordinates
    typedef struct packed {
        logic row_start;
        logic last;
    } tbr_flags_t;

    // bits in one byte of a stream word
    localparam int unsigned BYTE_BITS = 8;

endpackage

FILE: hdl/tbr_cover_stage.sv
// edge-function coverage test and output register of the rasterizer
module tbr_cover_stage #(
    parameter int unsigned COORD_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  tbr_pkg::tbr_flags_t    in_flags,
    input  logic [COORD_BITS-1:0]  vertex_a_x,
    input  logic [COORD_BITS-1:0]  vertex_a_y,
    input  logic [COORD_BITS-1:0]  vertex_b_x,
    input  logic [COORD_BITS-1:0]  vertex_b_y,
    input  logic [COORD_BITS-1:0]  vertex_c_x,
    input  logic [COORD_BITS-1:0]  vertex_c_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  out_x,
    output logic [COORD_BITS-1:0]  out_y,
    output logic                   out_covered,
    output tbr_pkg::tbr_flags_t    out_flags
);
    import tbr_pkg::*;

    localparam int unsigned DIFF_W  = COORD_BITS + 1;
    localparam int unsigned PROD_W  = 2 * COORD_BITS + 2;
    localparam int unsigned CROSS_W = PROD_W + 1;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_covered_reg;
    tbr_flags_t            out_flags_reg;
    logic                  covered_next;
    logic                  edge_ab;
    logic                  edge_bc;
    logic                  edge_ca;

    // cross product (v-u) x (p-u) strictly above zero
    function automatic logic edge_positive(
        input logic [COORD_BITS-1:0] ux,
        input logic [COORD_BITS-1:0] uy,
        input logic [COORD_BITS-1:0] vx,
        input logic [COORD_BITS-1:0] vy,
        input logic [COORD_BITS-1:0] px,
        input logic [COORD_BITS-1:0] py
    );
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  ex;
        logic signed [DIFF_W-1:0]  ey;
        logic signed [PROD_W-1:0]  p_pos;
        logic signed [PROD_W-1:0]  p_neg;
        logic signed [CROSS_W-1:0] cross_sum;
        dx    = $signed({1'b0, vx}) - $signed({1'b0, ux});
        dy    = $signed({1'b0, vy}) - $signed({1'b0, uy});
        ex    = $signed({1'b0, px}) - $signed({1'b0, ux});
        ey    = $signed({1'b0, py}) - $signed({1'b0, uy});
        p_pos = dx * ey;
        p_neg = dy * ex;
        cross_sum = $signed({p_pos[PROD_W-1], p_pos}) - $signed({p_neg[PROD_W-1], p_neg});
        return !cross_sum[CROSS_W-1] && (cross_sum != '0);
    endfunction

    // edge tests AB, BC and CA on the incoming pixel
    always_comb
    begin
        edge_ab = edge_positive(vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, in_x, in_y);
        edge_bc = edge_positive(vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, in_x, in_y);
        edge_ca = edge_positive(vertex_c_x, vertex_c_y, vertex_a_x, vertex_a_y, in_x, in_y);
        covered_next = edge_ab && edge_bc && edge_ca;
    end

    // output register takes a word when empty or being drained
    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            out_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the result word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_x_reg       <= in_x;
            out_y_reg       <= in_y;
            out_covered_reg <= covered_next;
            out_flags_reg   <= in_flags;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_covered = out_covered_reg;
    assign out_flags   = out_flags_reg;

endmodule

FILE: hdl/triangle_bbox_rasterizer_core.sv
// top level of the triangle bounding-box rasterizer
//
// Six vertex coordinate registers are written over the APB-style port (A x, A y,
// B x, B y, C x, C y at byte addresses 0, 4, ... 20); the user must see that they are
// changed only while the block is idle, as the block itself does not enforce it. Each
// input word on the s_ side is one step: tdata bit 0 set restarts the scan at the box
// corner, clear advances one pixel in row-major order. A step yields at most one
// output word on the m_ side: tdata holds pixel x then pixel y, tuser holds the
// covered and row-start flags, tlast marks the final pixel. An empty box, an advance
// with no scan running or an advance past the box end gives no word.
// An accepted step is registered in the pixel stage after the scan step, then in the
// output register, which drives m_tvalid, after the edge cross products AB, BC and CA.
// One step is taken every cycle while s_tready is high; the scan counters update in
// the accept cycle, so consecutive steps chain without a gap.
// Reset clears the vertices to zero, stops any scan and empties both stages.
// When the receiver stalls the two stages fill, then s_tready falls; nothing is
// dropped and words leave in order.
module triangle_bbox_rasterizer_core #(
    parameter int unsigned COORD_BITS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // apb configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [4:0]                                  paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready,
    // step words
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [tbr_pkg::BYTE_BITS-1:0]               s_tdata,  // [0] restart
    // pixel words
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_tdata,  // pixel_x, pixel_y
    output logic [1:0]                                  m_tuser,  // covered, row_start
    output logic                                        m_tlast
);
    import tbr_pkg::*;

    localparam int unsigned OUT_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned WIDE_W = COORD_BITS + 1;

    // register index codes
    typedef enum logic [2:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } tbr_reg_t;

    logic [COORD_BITS-1:0] vertex_a_x_reg;
    logic [COORD_BITS-1:0] vertex_a_y_reg;
    logic [COORD_BITS-1:0] vertex_b_x_reg;
    logic [COORD_BITS-1:0] vertex_b_y_reg;
    logic [COORD_BITS-1:0] vertex_c_x_reg;
    logic [COORD_BITS-1:0] vertex_c_y_reg;
    logic                  cfg_write;
    logic [2:0]            cfg_index;

    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;

    logic [COORD_BITS-1:0] scan_x_reg;
    logic [COORD_BITS-1:0] scan_x_next;
    logic [COORD_BITS-1:0] scan_y_reg;
    logic [COORD_BITS-1:0] scan_y_next;
    logic                  scan_active_reg;
    logic                  scan_active_next;
    logic                  step_accept;
    logic                  restart;
    logic                  box_ok;
    logic [WIDE_W-1:0]     x_inc;
    logic [WIDE_W-1:0]     y_inc;
    logic                  step_hit;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic                  step_end;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    tbr_flags_t            s1_flags_reg;
    logic                  s1_ready;

    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  out_covered;
    tbr_flags_t            out_flags;

    function automatic logic [COORD_BITS-1:0] lo3(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q,
        input logic [COORD_BITS-1:0] r
    );
        logic [COORD_BITS-1:0] m;
        m = (p < q) ? p : q;
        return (r < m) ? r : m;
    endfunction

    function automatic logic [COORD_BITS-1:0] hi3(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q,
        input logic [COORD_BITS-1:0] r
    );
        logic [COORD_BITS-1:0] m;
        m = (p > q) ? p : q;
        return (r > m) ? r : m;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_a_x_reg <= '0;
            vertex_a_y_reg <= '0;
            vertex_b_x_reg <= '0;
            vertex_b_y_reg <= '0;
            vertex_c_x_reg <= '0;
            vertex_c_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_A_X: vertex_a_x_reg <= pwdata[COORD_BITS-1:0];
                REG_A_Y: vertex_a_y_reg <= pwdata[COORD_BITS-1:0];
                REG_B_X: vertex_b_x_reg <= pwdata[COORD_BITS-1:0];
                REG_B_Y: vertex_b_y_reg <= pwdata[COORD_BITS-1:0];
                REG_C_X: vertex_c_x_reg <= pwdata[COORD_BITS-1:0];
                REG_C_Y: vertex_c_y_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (cfg_index)
            REG_A_X: prdata = 32'(vertex_a_x_reg);
            REG_A_Y: prdata = 32'(vertex_a_y_reg);
            REG_B_X: prdata = 32'(vertex_b_x_reg);
            REG_B_Y: prdata = 32'(vertex_b_y_reg);
            REG_C_X: prdata = 32'(vertex_c_x_reg);
            REG_C_Y: prdata = 32'(vertex_c_y_reg);
            default: prdata = '0;
        endcase
    end

    // bounding box of the triangle
    assign min_x  = lo3(vertex_a_x_reg, vertex_b_x_reg, vertex_c_x_reg);
    assign max_x  = hi3(vertex_a_x_reg, vertex_b_x_reg, vertex_c_x_reg);
    assign min_y  = lo3(vertex_a_y_reg, vertex_b_y_reg, vertex_c_y_reg);
    assign max_y  = hi3(vertex_a_y_reg, vertex_b_y_reg, vertex_c_y_reg);
    assign box_ok = (min_x < max_x) && (min_y < max_y);

    // scan step: pick the next pixel from the last one, or the box corner on a restart
    assign restart     = s_tdata[0];
    assign s_tready    = !s1_valid_reg || s1_ready;
    assign step_accept = s_tvalid && s_tready;
    assign x_inc       = {1'b0, scan_x_reg} + WIDE_W'(1);
    assign y_inc       = {1'b0, scan_y_reg} + WIDE_W'(1);

    always_comb
    begin
        step_hit = 1'b0;
        step_x   = min_x;
        step_y   = min_y;
        if (restart)
        begin
            step_hit = box_ok;
        end
        else if (scan_active_reg)
        begin
            if (x_inc < {1'b0, max_x})
            begin
                step_hit = 1'b1;
                step_x   = x_inc[COORD_BITS-1:0];
                step_y   = scan_y_reg;
            end
            else if (y_inc < {1'b0, max_y})
            begin
                step_hit = 1'b1;
                step_x   = min_x;
                step_y   = y_inc[COORD_BITS-1:0];
            end
        end
        step_end = (({1'b0, step_x} + WIDE_W'(1)) >= {1'b0, max_x})
                && (({1'b0, step_y} + WIDE_W'(1)) >= {1'b0, max_y});
    end

    // scan state
    always_comb
    begin
        scan_x_next      = scan_x_reg;
        scan_y_next      = scan_y_reg;
        scan_active_next = scan_active_reg;
        if (step_accept)
        begin
            scan_active_next = step_hit && !step_end;
            if (step_hit)
            begin
                scan_x_next = step_x;
                scan_y_next = step_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_x_reg      <= '0;
            scan_y_reg      <= '0;
            scan_active_reg <= 1'b0;
        end
        else
        begin
            scan_x_reg      <= scan_x_next;
            scan_y_reg      <= scan_y_next;
            scan_active_reg <= scan_active_next;
        end
    end

    // pixel stage between the scan step and the coverage test
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_tready)
        begin
            s1_valid_next = step_accept && step_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept && step_hit)
        begin
            s1_x_reg               <= step_x;
            s1_y_reg               <= step_y;
            s1_flags_reg.row_start <= (step_x == min_x);
            s1_flags_reg.last      <= step_end;
        end
    end

    // coverage test and output register
    tbr_cover_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_cover (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_ready    (s1_ready),
        .in_x        (s1_x_reg),
        .in_y        (s1_y_reg),
        .in_flags    (s1_flags_reg),
        .vertex_a_x  (vertex_a_x_reg),
        .vertex_a_y  (vertex_a_y_reg),
        .vertex_b_x  (vertex_b_x_reg),
        .vertex_b_y  (vertex_b_y_reg),
        .vertex_c_x  (vertex_c_x_reg),
        .vertex_c_y  (vertex_c_y_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_covered (out_covered),
        .out_flags   (out_flags)
    );

    // pack the output word
    assign m_tdata = OUT_W'({out_y, out_x});
    assign m_tuser = {out_flags.row_start, out_covered};
    assign m_tlast = out_flags.last;

`ifndef NO_ASSERTIONS
    // a restart over a non-empty box always loads the pixel stage
    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step_accept && restart && box_ok |=> s1_valid_reg)
        else $error("restart over a non-empty box produced no pixel");

    // an advance with no scan running produces nothing
    a_idle_advance_empty: assert property (@(posedge clk) disable iff (!rst_n)
        step_accept && !restart && !scan_active_reg |=> !s1_valid_reg)
        else $error("advance with no scan produced a pixel");

    // a stalled pixel stage keeps its coordinates
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(s1_x_reg) && $stable(s1_y_reg))
        else $error("pixel stage changed while stalled");

    // the scan counters only move on an accepted step
    a_scan_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !step_accept |=> $stable(scan_x_reg) && $stable(scan_y_reg))
        else $error("scan position moved without a step");
`endif

endmodule
